// ===== sv/cpf_pkg.sv =====
`timescale 1ns / 1ps
package cpf_pkg;

    // Fixed point formats
    localparam int QFB = 30;            // quaternion / matrix fraction bits
    localparam int QW  = 32;            // quaternion and matrix entry width
    localparam int PW  = 32;            // position width

    localparam logic signed [63:0] ONE   = 64'sd1 <<< QFB;
    localparam logic signed [63:0] ONE2  = 64'sd1 <<< (2 * QFB);
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (QFB - 1);
    localparam logic signed [63:0] P_MAX = 64'sd2147483647;
    localparam logic signed [63:0] P_MIN = -64'sd2147483648;
    localparam logic [QW-1:0]      ONE_Q = QW'(1) << QFB;

    typedef logic [8:0][QW-1:0] t_mat;
    typedef logic [2:0][PW-1:0] t_vec3;
    typedef logic [3:0][QW-1:0] t_quat;

    // Item passed from the front end to the back end through the queue
    typedef struct packed {
        t_mat  rl;
        t_vec3 lp;
    } t_item;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BASIS_POS_X  = 3'd0,
        CFG_BASIS_POS_Y  = 3'd1,
        CFG_BASIS_POS_Z  = 3'd2,
        CFG_BASIS_QUAT_X = 3'd3,
        CFG_BASIS_QUAT_Y = 3'd4,
        CFG_BASIS_QUAT_Z = 3'd5,
        CFG_BASIS_QUAT_W = 3'd6
    } t_cfg_idx;

    function automatic logic signed [63:0] f_sx(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [QW-1:0] f_clamp_one(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > ONE) c = ONE;
        else if (v < -ONE) c = -ONE;
        else c = v;
        return c[QW-1:0];
    endfunction

    // Right shift by QFB, rounding half up
    function automatic logic signed [63:0] f_rsh(input logic signed [63:0] v);
        return (v + HALF) >>> QFB;
    endfunction

    function automatic logic signed [63:0] f_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p;
    endfunction

endpackage

// ===== sv/compose_pose_in_frame.sv =====
`timescale 1ns / 1ps
// Path from input transaction to result: 3 front-end stages, queue, 100 back-end stages
// (32 square root, 62 divider steps). Throughput: one pose per cycle when the output
// is not stalled, bounded by the queue credit loop.
// Reset (i_rst_n low, synchronous) clears pipeline valids, queue and credit count;
// the basis pose returns to the identity.
module compose_pose_in_frame #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // local_pos_x/y/z, local_quat_x/y/z/w, 32 bits each from bit 0 up
    input  logic [223:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // world_pos_x/y/z, world_quat_x/y/z/w, 32 bits each from bit 0 up
    output logic [223:0] m_axis_tdata,
    // pos_saturated
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Basis pose registers
    cpf_pkg::t_vec3 r_bp;
    cpf_pkg::t_quat r_bq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp <= '0;
            r_bq <= {cpf_pkg::ONE_Q, {(3 * cpf_pkg::QW){1'b0}}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cpf_pkg::CFG_BASIS_POS_X:  r_bp[0] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_POS_Y:  r_bp[1] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_POS_Z:  r_bp[2] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_QUAT_X: r_bq[0] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_QUAT_Y: r_bq[1] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_QUAT_Z: r_bq[2] <= i_cfg_data;
                cpf_pkg::CFG_BASIS_QUAT_W: r_bq[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Basis rotation matrix, refreshed continuously
    cpf_pkg::t_quat w_bqc;
    cpf_pkg::t_mat  w_rb;

    always_comb begin
        for (int n = 0; n < 4; n++) w_bqc[n] = cpf_pkg::f_clamp_one(cpf_pkg::f_sx(r_bq[n]));
    end

    cpf_q2m u_basis (
        .i_clk (i_clk),
        .i_q   (w_bqc),
        .o_m   (w_rb)
    );

    // Credit count: items accepted and not yet taken from the queue
    logic [CW-1:0] r_credit;
    logic          w_accept, w_pop;

    assign s_axis_tready = (r_credit < CW'(QUEUE_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_credit <= '0;
        else r_credit <= r_credit + CW'(w_accept) - CW'(w_pop);
    end

    // Front end
    cpf_pkg::t_vec3 w_in_pos;
    cpf_pkg::t_quat w_in_quat;
    logic           w_front_valid;
    cpf_pkg::t_item w_front_item;

    always_comb begin
        for (int n = 0; n < 3; n++) w_in_pos[n] = s_axis_tdata[32*n +: 32];
        for (int n = 0; n < 4; n++) w_in_quat[n] = s_axis_tdata[96 + 32*n +: 32];
    end

    cpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_pos   (w_in_pos),
        .i_quat  (w_in_quat),
        .o_valid (w_front_valid),
        .o_item  (w_front_item)
    );

    // Queue
    cpf_pkg::t_item w_q_item;
    logic           w_q_empty, w_q_full;

    cpf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_valid),
        .i_data  (w_front_item),
        .i_rd    (w_pop),
        .o_data  (w_q_item),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Back end
    cpf_pkg::t_vec3 w_out_pos;
    cpf_pkg::t_quat w_out_quat;
    logic           w_out_sat;

    cpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_q_empty),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .i_rb    (w_rb),
        .i_bp    (r_bp),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pos   (w_out_pos),
        .o_quat  (w_out_quat),
        .o_sat   (w_out_sat)
    );

    always_comb begin
        for (int n = 0; n < 3; n++) m_axis_tdata[32*n +: 32] = w_out_pos[n];
        for (int n = 0; n < 4; n++) m_axis_tdata[96 + 32*n +: 32] = w_out_quat[n];
        m_axis_tuser[0] = w_out_sat;
    end

    // Checks
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CW'(QUEUE_DEPTH))
        else $error("credit count above queue depth");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_valid |-> !w_q_full)
        else $error("front end wrote a full queue");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (w_out_pos[0] == 32'h7FFF_FFFF || w_out_pos[0] == 32'h8000_0000 ||
             w_out_pos[1] == 32'h7FFF_FFFF || w_out_pos[1] == 32'h8000_0000 ||
             w_out_pos[2] == 32'h7FFF_FFFF || w_out_pos[2] == 32'h8000_0000))
        else $error("saturation flag without a clipped component");

    a_pop_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_credit != '0))
        else $error("queue read without an outstanding item");
endmodule

// ===== sv/cpf_q2m.sv =====
`timescale 1ns / 1ps
// Quaternion to rotation matrix, two register stages
module cpf_q2m (
    input  logic          i_clk,
    input  cpf_pkg::t_quat i_q,
    output cpf_pkg::t_mat  o_m
);
    logic signed [63:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    cpf_pkg::t_mat      r_m;
    logic signed [63:0] e [9];

    // Stage 1: component products
    always_ff @(posedge i_clk) begin
        r_xx <= cpf_pkg::f_mul(i_q[0], i_q[0]);
        r_yy <= cpf_pkg::f_mul(i_q[1], i_q[1]);
        r_zz <= cpf_pkg::f_mul(i_q[2], i_q[2]);
        r_xy <= cpf_pkg::f_mul(i_q[0], i_q[1]);
        r_wz <= cpf_pkg::f_mul(i_q[3], i_q[2]);
        r_xz <= cpf_pkg::f_mul(i_q[0], i_q[2]);
        r_wy <= cpf_pkg::f_mul(i_q[3], i_q[1]);
        r_yz <= cpf_pkg::f_mul(i_q[1], i_q[2]);
        r_wx <= cpf_pkg::f_mul(i_q[3], i_q[0]);
    end

    // Stage 2: entries, rounded and clamped to +-1
    always_comb begin
        e[0] = cpf_pkg::ONE2 - ((r_yy + r_zz) <<< 1);
        e[1] = (r_xy - r_wz) <<< 1;
        e[2] = (r_xz + r_wy) <<< 1;
        e[3] = (r_xy + r_wz) <<< 1;
        e[4] = cpf_pkg::ONE2 - ((r_xx + r_zz) <<< 1);
        e[5] = (r_yz - r_wx) <<< 1;
        e[6] = (r_xz - r_wy) <<< 1;
        e[7] = (r_yz + r_wx) <<< 1;
        e[8] = cpf_pkg::ONE2 - ((r_xx + r_yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        for (int n = 0; n < 9; n++) begin
            r_m[n] <= cpf_pkg::f_clamp_one(cpf_pkg::f_rsh(e[n]));
        end
    end

    assign o_m = r_m;
endmodule

// ===== sv/cpf_front.sv =====
`timescale 1ns / 1ps
// Front end: registers accepted poses and expands the local quaternion
module cpf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cpf_pkg::t_vec3  i_pos,
    input  cpf_pkg::t_quat  i_quat,
    output logic            o_valid,
    output cpf_pkg::t_item  o_item
);
    logic           r_v0, r_v1, r_v2;
    cpf_pkg::t_vec3 r_p0, r_p1, r_p2;
    cpf_pkg::t_quat r_q0;
    cpf_pkg::t_quat w_qc;
    cpf_pkg::t_mat  w_rl;

    // Input register
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_p0 <= i_pos;
            r_q0 <= i_quat;
        end
        r_p1 <= r_p0;
        r_p2 <= r_p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Clamp components to +-1 before expansion
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            w_qc[n] = cpf_pkg::f_clamp_one(cpf_pkg::f_sx(r_q0[n]));
        end
    end

    cpf_q2m u_q2m (
        .i_clk (i_clk),
        .i_q   (w_qc),
        .o_m   (w_rl)
    );

    assign o_valid   = r_v2;
    assign o_item.rl = w_rl;
    assign o_item.lp = r_p2;
endmodule

// ===== sv/cpf_fifo.sv =====
`timescale 1ns / 1ps
// Queue between front and back ends
module cpf_fifo #(
    parameter int DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  cpf_pkg::t_item i_data,
    input  logic           i_rd,
    output cpf_pkg::t_item o_data,
    output logic           o_empty,
    output logic           o_full
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cpf_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_rd) r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            r_count <= r_count + CW'(i_wr) - CW'(i_rd);
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
endmodule

// ===== sv/cpf_back.sv =====
`timescale 1ns / 1ps
// Back end: composes the transforms and converts the product matrix back
// to a quaternion through a pipelined square root and three dividers
module cpf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cpf_pkg::t_item  i_item,
    output logic            o_pop,
    input  cpf_pkg::t_mat   i_rb,
    input  cpf_pkg::t_vec3  i_bp,
    output logic            o_valid,
    input  logic            i_ready,
    output cpf_pkg::t_vec3  o_pos,
    output cpf_pkg::t_quat  o_quat,
    output logic            o_sat
);
    localparam int SQ_N = 32;                      // square root steps
    localparam int RADW = 63;                      // radicand width
    localparam int AW   = 32 + cpf_pkg::QFB;       // dividend width
    localparam int DV_N = AW;                      // divider steps
    localparam int DW   = 33;                      // divisor width
    localparam int DQW  = 33;                      // numerator difference width

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    // ---------------- stage 1: products ----------------
    logic               r1_v;
    logic signed [63:0] r1_pm [9][3];
    logic signed [63:0] r1_pp [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r1_pm[i*3+j][k] <= cpf_pkg::f_mul(i_rb[i*3+k], i_item.rl[k*3+j]);
                    end
                    r1_pp[i][j] <= cpf_pkg::f_mul(i_rb[i*3+j], i_item.lp[j]);
                end
            end
        end
    end

    // ---------------- stage 2: sums, rounding, saturation ----------------
    logic               r2_v;
    cpf_pkg::t_mat      r2_m;
    cpf_pkg::t_vec3     r2_p;
    logic               r2_sat;
    cpf_pkg::t_mat      b2_m;
    cpf_pkg::t_vec3     b2_p;
    logic               b2_sat;
    logic signed [63:0] b2_acc, b2_pv;

    always_comb begin
        b2_sat = 1'b0;
        b2_acc = '0;
        b2_pv  = '0;
        for (int n = 0; n < 9; n++) begin
            b2_acc  = r1_pm[n][0] + r1_pm[n][1] + r1_pm[n][2];
            b2_m[n] = cpf_pkg::f_clamp_one(cpf_pkg::f_rsh(b2_acc));
        end
        for (int i = 0; i < 3; i++) begin
            b2_acc = r1_pp[i][0] + r1_pp[i][1] + r1_pp[i][2];
            b2_pv  = cpf_pkg::f_rsh(b2_acc) + cpf_pkg::f_sx(i_bp[i]);
            if (b2_pv > cpf_pkg::P_MAX) begin
                b2_pv  = cpf_pkg::P_MAX;
                b2_sat = 1'b1;
            end else if (b2_pv < cpf_pkg::P_MIN) begin
                b2_pv  = cpf_pkg::P_MIN;
                b2_sat = 1'b1;
            end
            b2_p[i] = b2_pv[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_m   <= b2_m;
            r2_p   <= b2_p;
            r2_sat <= b2_sat;
        end
    end

    // ---------------- stage 3: trace and largest diagonal ----------------
    logic               r3_v;
    cpf_pkg::t_mat      r3_m;
    cpf_pkg::t_vec3     r3_p;
    logic               r3_sat;
    logic signed [63:0] r3_t;
    logic [1:0]         r3_i;
    logic signed [63:0] b3_t;
    logic [1:0]         b3_i;

    always_comb begin
        b3_t = cpf_pkg::f_sx(r2_m[0]) + cpf_pkg::f_sx(r2_m[4]) + cpf_pkg::f_sx(r2_m[8]);
        b3_i = 2'd0;
        if ($signed(r2_m[4]) > $signed(r2_m[0])) b3_i = 2'd1;
        if ((b3_i == 2'd1) ? ($signed(r2_m[8]) > $signed(r2_m[4]))
                           : ($signed(r2_m[8]) > $signed(r2_m[0]))) b3_i = 2'd2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_m   <= r2_m;
            r3_p   <= r2_p;
            r3_sat <= r2_sat;
            r3_t   <= b3_t;
            r3_i   <= b3_i;
        end
    end

    // ---------------- stage 4: branch select, radicand, numerators --------
    logic [RADW-1:0]      sq_n   [0:SQ_N];
    logic [RADW-1:0]      sq_r   [0:SQ_N];
    logic [1:0]           sq_mi  [0:SQ_N];
    logic [3:0][DQW-1:0]  sq_dq  [0:SQ_N];
    cpf_pkg::t_vec3       sq_p   [0:SQ_N];
    logic                 sq_sat [0:SQ_N];
    logic                 sq_v   [0:SQ_N];

    logic signed [63:0]   b4_m [9];
    logic signed [63:0]   b4_v;
    logic signed [63:0]   b4_dq [4];
    logic [RADW-1:0]      b4_rad;
    logic [1:0]           b4_mi;

    always_comb begin
        for (int n = 0; n < 9; n++) b4_m[n] = cpf_pkg::f_sx(r3_m[n]);
        b4_v = '0;
        for (int n = 0; n < 4; n++) b4_dq[n] = '0;
        if (r3_t > 0) begin
            b4_mi    = 2'd3;
            b4_rad   = RADW'((r3_t + cpf_pkg::ONE) <<< cpf_pkg::QFB);
            b4_dq[0] = b4_m[7] - b4_m[5];
            b4_dq[1] = b4_m[2] - b4_m[6];
            b4_dq[2] = b4_m[3] - b4_m[1];
        end else begin
            b4_mi = r3_i;
            unique case (r3_i)
                2'd1: begin
                    b4_v     = b4_m[4] - b4_m[8] - b4_m[0] + cpf_pkg::ONE;
                    b4_dq[3] = b4_m[2] - b4_m[6];
                    b4_dq[2] = b4_m[7] + b4_m[5];
                    b4_dq[0] = b4_m[1] + b4_m[3];
                end
                2'd2: begin
                    b4_v     = b4_m[8] - b4_m[0] - b4_m[4] + cpf_pkg::ONE;
                    b4_dq[3] = b4_m[3] - b4_m[1];
                    b4_dq[0] = b4_m[2] + b4_m[6];
                    b4_dq[1] = b4_m[5] + b4_m[7];
                end
                default: begin
                    b4_v     = b4_m[0] - b4_m[4] - b4_m[8] + cpf_pkg::ONE;
                    b4_dq[3] = b4_m[7] - b4_m[5];
                    b4_dq[1] = b4_m[3] + b4_m[1];
                    b4_dq[2] = b4_m[6] + b4_m[2];
                end
            endcase
            if (b4_v < 0) b4_v = '0;
            b4_rad = RADW'(b4_v <<< cpf_pkg::QFB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            sq_n[0]   <= b4_rad;
            sq_r[0]   <= '0;
            sq_mi[0]  <= b4_mi;
            for (int n = 0; n < 4; n++) sq_dq[0][n] <= b4_dq[n][DQW-1:0];
            sq_p[0]   <= r3_p;
            sq_sat[0] <= r3_sat;
        end
    end

    // Valid bits of the first four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            sq_v[0] <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            sq_v[0] <= r3_v;
        end
    end

    // ---------------- square root: one result bit per stage ----------------
    for (genvar g = 1; g <= SQ_N; g++) begin : g_sqrt
        localparam logic [63:0] SBIT = 64'd1 << (2 * (SQ_N - g));
        logic [63:0] s_sum;
        logic [63:0] s_n;

        always_comb begin
            s_sum = {1'b0, sq_r[g-1]} + SBIT;
            s_n   = {1'b0, sq_n[g-1]};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (s_n >= s_sum) begin
                    sq_n[g] <= RADW'(s_n - s_sum);
                    sq_r[g] <= RADW'({2'b0, sq_r[g-1][RADW-1:1]} + SBIT);
                end else begin
                    sq_n[g] <= sq_n[g-1];
                    sq_r[g] <= {1'b0, sq_r[g-1][RADW-1:1]};
                end
                sq_mi[g]  <= sq_mi[g-1];
                sq_dq[g]  <= sq_dq[g-1];
                sq_p[g]   <= sq_p[g-1];
                sq_sat[g] <= sq_sat[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) sq_v[g] <= 1'b0;
            else if (en) sq_v[g] <= sq_v[g-1];
        end
    end

    // ---------------- divider set-up ----------------
    logic [2:0][AW-1:0]  dv_a   [0:DV_N];
    logic [2:0][DW-1:0]  dv_rem [0:DV_N];
    logic [2:0][31:0]    dv_q   [0:DV_N];
    logic [2:0]          dv_neg [0:DV_N];
    logic [DW-1:0]       dv_d   [0:DV_N];
    logic [31:0]         dv_qm  [0:DV_N];
    logic [1:0]          dv_mi  [0:DV_N];
    cpf_pkg::t_vec3      dv_p   [0:DV_N];
    logic                dv_sat [0:DV_N];
    logic                dv_v   [0:DV_N];

    logic [31:0]          d0_s;
    logic [32:0]          d0_s1;
    logic [1:0]           d0_c;
    logic signed [DQW-1:0] d0_diff;
    logic [DQW-1:0]       d0_mag;
    logic [2:0][AW-1:0]   d0_a;
    logic [2:0]           d0_neg;

    always_comb begin
        d0_s    = (sq_r[SQ_N][31:0] == '0) ? 32'd1 : sq_r[SQ_N][31:0];
        d0_s1   = {1'b0, d0_s} + 33'd1;
        d0_c    = '0;
        d0_diff = '0;
        d0_mag  = '0;
        for (int j = 0; j < 3; j++) begin
            d0_c      = 2'(j) + ((2'(j) >= sq_mi[SQ_N]) ? 2'd1 : 2'd0);
            d0_diff   = $signed(sq_dq[SQ_N][d0_c]);
            d0_neg[j] = d0_diff[DQW-1];
            d0_mag    = d0_neg[j] ? DQW'(-d0_diff) : DQW'(d0_diff);
            d0_a[j]   = AW'({d0_mag[31:0], cpf_pkg::QFB'(0)}) + AW'(d0_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_a[0]   <= d0_a;
            dv_rem[0] <= '0;
            dv_q[0]   <= '0;
            dv_neg[0] <= d0_neg;
            dv_d[0]   <= {d0_s, 1'b0};
            dv_qm[0]  <= d0_s1[32:1];
            dv_mi[0]  <= sq_mi[SQ_N];
            dv_p[0]   <= sq_p[SQ_N];
            dv_sat[0] <= sq_sat[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) dv_v[0] <= 1'b0;
        else if (en) dv_v[0] <= sq_v[SQ_N];
    end

    // ---------------- restoring dividers: one quotient bit per stage -------
    for (genvar g = 1; g <= DV_N; g++) begin : g_div
        logic [2:0][DW:0] t_rs;
        logic [2:0]       t_ge;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                t_rs[j] = {dv_rem[g-1][j], dv_a[g-1][j][AW-g]};
                t_ge[j] = (t_rs[j] >= {1'b0, dv_d[g-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    dv_rem[g][j] <= t_ge[j] ? DW'(t_rs[j] - {1'b0, dv_d[g-1]})
                                            : t_rs[j][DW-1:0];
                    dv_q[g][j]   <= {dv_q[g-1][j][30:0], t_ge[j]};
                end
                dv_a[g]   <= dv_a[g-1];
                dv_neg[g] <= dv_neg[g-1];
                dv_d[g]   <= dv_d[g-1];
                dv_qm[g]  <= dv_qm[g-1];
                dv_mi[g]  <= dv_mi[g-1];
                dv_p[g]   <= dv_p[g-1];
                dv_sat[g] <= dv_sat[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) dv_v[g] <= 1'b0;
            else if (en) dv_v[g] <= dv_v[g-1];
        end
    end

    // ---------------- output register ----------------
    logic           r_o_valid;
    cpf_pkg::t_vec3 r_o_pos;
    cpf_pkg::t_quat r_o_quat;
    logic           r_o_sat;
    cpf_pkg::t_quat f_quat;
    logic [1:0]     f_slot;
    logic [31:0]    f_q;

    always_comb begin
        f_slot = '0;
        f_q    = '0;
        for (int c = 0; c < 4; c++) begin
            if (2'(c) == dv_mi[DV_N]) begin
                f_quat[c] = dv_qm[DV_N];
            end else begin
                f_slot    = 2'(c) - ((2'(c) > dv_mi[DV_N]) ? 2'd1 : 2'd0);
                f_q       = dv_q[DV_N][f_slot];
                f_quat[c] = dv_neg[DV_N][f_slot] ? (~f_q + 32'd1) : f_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pos  <= dv_p[DV_N];
            r_o_quat <= f_quat;
            r_o_sat  <= dv_sat[DV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (en) r_o_valid <= dv_v[DV_N];
    end

    assign o_valid = r_o_valid;
    assign o_pos   = r_o_pos;
    assign o_quat  = r_o_quat;
    assign o_sat   = r_o_sat;
endmodule
